/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SCM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/scm_pkg.sv */
// Constants and codes shared by the contour marker files.
package scm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LABEL_BITS = 16;

  localparam int ENT_BITS   = LABEL_BITS + 1;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int DIM_BITS   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH + 1 : MAX_HEIGHT + 1);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT + 4) > DIM_BITS ? $clog2(MAX_HEIGHT + 4)
                                                                 : DIM_BITS;
  localparam int T_BITS     = $clog2(MAX_WIDTH * (MAX_HEIGHT + 3) + 2);

  localparam int REG_BITS   = 11;
  localparam int SIZE_BITS  = 21;
  localparam int PADDR_BITS = 4;

  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_SIZE_THRESHOLD = 2'd2;

  localparam logic [1:0] PAINT_KEEP  = 2'd0;
  localparam logic [1:0] PAINT_WHITE = 2'd1;
  localparam logic [1:0] PAINT_BLACK = 2'd2;

endpackage

/* rtl/scm_ram.sv */
// Simple dual-port RAM with registered read data.
module scm_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/segment_contour_marker.sv */
// Contour marker: one request per cycle while the output is not stalled, results in raster order,
// 2*W+2 requests behind. A result is registered through s1, s2 and s3 after the request that produces it.
// Throughput 1 request per cycle while out_ready does not stall the output stage, set by the label and
// contour line RAMs (one read-modify-write per request each, same-entry overlap forwarded).
// Synchronous reset clears counters and pipeline valid flags and sets registers to defaults; line RAMs are not cleared.
module segment_contour_marker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scm_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic [scm_pkg::LABEL_BITS-1:0]      pixel_label,
  input  logic [scm_pkg::SIZE_BITS-1:0]       segment_size,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          paint,
  output logic                                is_contour,
  output logic                                frame_last
);

  typedef struct packed {
    logic [scm_pkg::COL_BITS-1:0] col;
    logic [scm_pkg::ENT_BITS-1:0] ent;
    logic                         p_act;
    logic                         p_in;
    logic [scm_pkg::COL_BITS-1:0] pc;
    logic                         pl, prt, pu, pd;
    logic                         q_act;
    logic                         q_last;
    logic                         ql, qrt, qu, qd;
  } stage_t;

  function automatic logic [scm_pkg::DIM_BITS-1:0] clamp_dim(
    input logic [scm_pkg::REG_BITS-1:0] v,
    input logic [scm_pkg::DIM_BITS-1:0] maxv
  );
    logic [scm_pkg::DIM_BITS:0] ve;
    ve = (scm_pkg::DIM_BITS + 1)'(v);
    if (v == '0) return scm_pkg::DIM_BITS'(1);
    if (ve > {1'b0, maxv}) return maxv;
    return ve[scm_pkg::DIM_BITS-1:0];
  endfunction

  // configuration
  logic [scm_pkg::REG_BITS-1:0]  frame_width;
  logic [scm_pkg::REG_BITS-1:0]  frame_height;
  logic [scm_pkg::SIZE_BITS-1:0] size_threshold;
  logic [1:0]                    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[scm_pkg::PADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= scm_pkg::REG_BITS'(640);
      frame_height   <= scm_pkg::REG_BITS'(480);
      size_threshold <= scm_pkg::SIZE_BITS'(100);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        scm_pkg::REG_FRAME_WIDTH:    frame_width    <= pwdata[scm_pkg::REG_BITS-1:0];
        scm_pkg::REG_FRAME_HEIGHT:   frame_height   <= pwdata[scm_pkg::REG_BITS-1:0];
        scm_pkg::REG_SIZE_THRESHOLD: size_threshold <= pwdata[scm_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scm_pkg::REG_FRAME_WIDTH:    prdata = 32'(frame_width);
      scm_pkg::REG_FRAME_HEIGHT:   prdata = 32'(frame_height);
      scm_pkg::REG_SIZE_THRESHOLD: prdata = 32'(size_threshold);
      default:                     prdata = '0;
    endcase
  end

  // frame position counters
  logic [scm_pkg::T_BITS-1:0]   t_cnt;
  logic [scm_pkg::ROW_BITS-1:0] row_cnt, pr_cnt, qr_cnt;
  logic [scm_pkg::COL_BITS-1:0] col_cnt, pc_cnt, qc_cnt;
  logic [scm_pkg::DIM_BITS-1:0] cur_w, cur_h;

  logic                         idle, in_frame, ignore, go, move;
  logic                         p_act, q_act, q_last;
  logic [scm_pkg::DIM_BITS-1:0] w_use, h_use, w_m1, h_m1;
  logic [scm_pkg::T_BITS-1:0]   w_p1, w2_p2;
  stage_t                       s_in, s1, s2, s3;
  logic                         s1_v, s2_v, s3_v;

  assign idle  = (t_cnt == '0);
  assign w_use = idle ? clamp_dim(frame_width, scm_pkg::DIM_BITS'(scm_pkg::MAX_WIDTH))
                      : cur_w;
  assign h_use = idle ? clamp_dim(frame_height, scm_pkg::DIM_BITS'(scm_pkg::MAX_HEIGHT))
                      : cur_h;
  assign w_m1  = w_use - scm_pkg::DIM_BITS'(1);
  assign h_m1  = h_use - scm_pkg::DIM_BITS'(1);
  assign w_p1  = scm_pkg::T_BITS'(w_use) + scm_pkg::T_BITS'(1);
  assign w2_p2 = (scm_pkg::T_BITS'(w_use) << 1) + scm_pkg::T_BITS'(2);

  assign in_frame = row_cnt < scm_pkg::ROW_BITS'(h_use);
  assign ignore   = action && in_frame;
  assign move     = !s3_v || out_ready;
  assign in_ready = move;
  assign go       = in_valid && move && !ignore;
  assign p_act    = t_cnt >= w_p1;
  assign q_act    = t_cnt >= w2_p2;
  assign q_last   = (qr_cnt == scm_pkg::ROW_BITS'(h_m1)) &&
                    (scm_pkg::DIM_BITS'(qc_cnt) == w_m1);

  always_comb begin
    s_in.col    = col_cnt;
    s_in.ent    = {segment_size > size_threshold, pixel_label};
    s_in.p_act  = p_act;
    s_in.p_in   = pr_cnt < scm_pkg::ROW_BITS'(h_use);
    s_in.pc     = pc_cnt;
    s_in.pl     = pc_cnt != '0;
    s_in.prt    = scm_pkg::DIM_BITS'(pc_cnt) != w_m1;
    s_in.pu     = pr_cnt != '0;
    s_in.pd     = pr_cnt != scm_pkg::ROW_BITS'(h_m1);
    s_in.q_act  = q_act;
    s_in.q_last = q_last;
    s_in.ql     = qc_cnt != '0;
    s_in.qrt    = scm_pkg::DIM_BITS'(qc_cnt) != w_m1;
    s_in.qu     = qr_cnt != '0;
    s_in.qd     = qr_cnt != scm_pkg::ROW_BITS'(h_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_cnt   <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
      pr_cnt  <= '0;
      pc_cnt  <= '0;
      qr_cnt  <= '0;
      qc_cnt  <= '0;
      cur_w   <= scm_pkg::DIM_BITS'(1);
      cur_h   <= scm_pkg::DIM_BITS'(1);
    end else if (go) begin
      if (idle) begin
        cur_w <= w_use;
        cur_h <= h_use;
      end
      if (q_act && q_last) begin
        t_cnt   <= '0;
        row_cnt <= '0;
        col_cnt <= '0;
        pr_cnt  <= '0;
        pc_cnt  <= '0;
        qr_cnt  <= '0;
        qc_cnt  <= '0;
      end else begin
        t_cnt <= t_cnt + scm_pkg::T_BITS'(1);
        if (scm_pkg::DIM_BITS'(col_cnt) == w_m1) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + scm_pkg::ROW_BITS'(1);
        end else begin
          col_cnt <= col_cnt + scm_pkg::COL_BITS'(1);
        end
        if (p_act) begin
          if (scm_pkg::DIM_BITS'(pc_cnt) == w_m1) begin
            pc_cnt <= '0;
            pr_cnt <= pr_cnt + scm_pkg::ROW_BITS'(1);
          end else begin
            pc_cnt <= pc_cnt + scm_pkg::COL_BITS'(1);
          end
        end
        if (q_act) begin
          if (scm_pkg::DIM_BITS'(qc_cnt) == w_m1) begin
            qc_cnt <= '0;
            qr_cnt <= qr_cnt + scm_pkg::ROW_BITS'(1);
          end else begin
            qc_cnt <= qc_cnt + scm_pkg::COL_BITS'(1);
          end
        end
      end
    end
  end

  // pipeline stages all advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (move) begin
      s1_v <= go;
      s2_v <= s1_v;
      s3_v <= s2_v && s2.q_act;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s1 <= s_in;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // label line RAM: entry holds {row-1, row-2} of one column
  logic [2*scm_pkg::ENT_BITS-1:0] lab_q, lab_rd, lab_wdata, lab_byp;
  logic                           lab_byp_v, lab_we;
  logic [scm_pkg::ENT_BITS-1:0]   lab_top, lab_mid;
  logic [scm_pkg::ENT_BITS-1:0]   lw [0:2][0:2];

  assign lab_we    = s1_v && move;
  assign lab_rd    = lab_byp_v ? lab_byp : lab_q;
  assign lab_mid   = lab_rd[2*scm_pkg::ENT_BITS-1:scm_pkg::ENT_BITS];
  assign lab_top   = lab_rd[scm_pkg::ENT_BITS-1:0];
  assign lab_wdata = {s1.ent, lab_mid};

  scm_ram #(
    .ADDR_BITS (scm_pkg::COL_BITS),
    .DATA_BITS (2*scm_pkg::ENT_BITS)
  ) u_lab_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (s1.col),
    .wdata (lab_wdata),
    .re    (go),
    .raddr (col_cnt),
    .rdata (lab_q)
  );

  // forward a write-back that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      lab_byp_v <= 1'b0;
    end else if (go) begin
      lab_byp_v <= s1_v && (s1.col == col_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      lab_byp <= lab_wdata;
    end
  end

  // 3x3 label window: [column][row], column 0 newest, row 0 top
  always_ff @(posedge clk) begin
    if (lab_we) begin
      lw[2]    <= lw[1];
      lw[1]    <= lw[0];
      lw[0][0] <= lab_top;
      lw[0][1] <= lab_mid;
      lw[0][2] <= s1.ent;
    end
  end

  // contour decision for the window center
  logic [scm_pkg::LABEL_BITS-1:0] ctr_lbl;
  logic [7:0]                     nd;
  logic                           ctr_ok, c_new;

  assign ctr_lbl = lw[1][1][scm_pkg::LABEL_BITS-1:0];
  assign ctr_ok  = lw[1][1][scm_pkg::LABEL_BITS] && (ctr_lbl != '1) && s2.p_in;

  always_comb begin
    nd[0] = s2.pl  && s2.pu && (lw[2][0][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[1] = s2.pl           && (lw[2][1][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[2] = s2.pl  && s2.pd && (lw[2][2][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[3] = s2.prt && s2.pu && (lw[0][0][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[4] = s2.prt          && (lw[0][1][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[5] = s2.prt && s2.pd && (lw[0][2][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[6] = s2.pu           && (lw[1][0][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
    nd[7] = s2.pd           && (lw[1][2][scm_pkg::LABEL_BITS-1:0] != ctr_lbl);
  end

  // more than one differing neighbor
  assign c_new = ctr_ok && ((nd & (nd - 8'd1)) != '0);

  // contour line RAM: entry holds {row-1, row-2} of one column
  logic [1:0] con_q, con_rd, con_wdata, con_byp;
  logic       con_byp_v, con_we, con_re;
  logic [2:0] cw [0:2];

  assign con_re    = s1_v && s1.p_act && move;
  assign con_we    = s2_v && s2.p_act && move;
  assign con_rd    = con_byp_v ? con_byp : con_q;
  assign con_wdata = {c_new, con_rd[1]};

  scm_ram #(
    .ADDR_BITS (scm_pkg::COL_BITS),
    .DATA_BITS (2)
  ) u_con_ram (
    .clk   (clk),
    .we    (con_we),
    .waddr (s2.pc),
    .wdata (con_wdata),
    .re    (con_re),
    .raddr (s1.pc),
    .rdata (con_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      con_byp_v <= 1'b0;
    end else if (con_re) begin
      con_byp_v <= s2_v && s2.p_act && (s2.pc == s1.pc);
    end
  end

  always_ff @(posedge clk) begin
    if (con_re) begin
      con_byp <= con_wdata;
    end
  end

  // 3x3 contour window, bit 0 top, bit 2 bottom
  always_ff @(posedge clk) begin
    if (con_we) begin
      cw[2] <= cw[1];
      cw[1] <= cw[0];
      cw[0] <= {c_new, con_rd[1], con_rd[0]};
    end
  end

  // output stage
  logic self_c, near_c;

  assign self_c = cw[1][1];
  assign near_c = (s3.ql  && s3.qu && cw[2][0]) || (s3.ql && cw[2][1]) ||
                  (s3.ql  && s3.qd && cw[2][2]) ||
                  (s3.qrt && s3.qu && cw[0][0]) || (s3.qrt && cw[0][1]) ||
                  (s3.qrt && s3.qd && cw[0][2]) ||
                  (s3.qu && cw[1][0]) || (s3.qd && cw[1][2]);

  assign out_valid  = s3_v;
  assign is_contour = self_c;
  assign frame_last = s3.q_last;
  assign paint      = self_c ? scm_pkg::PAINT_WHITE :
                      (near_c ? scm_pkg::PAINT_BLACK : scm_pkg::PAINT_KEEP);

endmodule

/* rtl/scm_checker.sv */
// Port-level checks for the contour marker, bound to the top level.
`include "assert_macros.svh"

module scm_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] paint,
  input logic       is_contour,
  input logic       frame_last
);

  `SCM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(paint) && $stable(is_contour) && $stable(frame_last), "stalled result changed")
  `SCM_ASSERT(a_paint_code, clk, rst, out_valid |-> (paint == scm_pkg::PAINT_KEEP || paint == scm_pkg::PAINT_WHITE || paint == scm_pkg::PAINT_BLACK), "bad paint code")
  `SCM_ASSERT(a_contour_white, clk, rst, out_valid |-> (is_contour == (paint == scm_pkg::PAINT_WHITE)), "contour flag and white paint disagree")
  `SCM_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid && pready, "result shown right after reset")

endmodule

bind segment_contour_marker scm_checker u_scm_checker (
  .clk        (clk),
  .rst        (rst),
  .pready     (pready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .paint      (paint),
  .is_contour (is_contour),
  .frame_last (frame_last)
);
